[rtl/core/min_priority_queue_with_path_top_defines.svh]
// assertion macros used by the checker file
`ifndef MIN_PRIORITY_QUEUE_WITH_PATH_TOP_DEFINES_SVH
`define MIN_PRIORITY_QUEUE_WITH_PATH_TOP_DEFINES_SVH

// same-cycle implication, sampled on clk, off during reset
`define MPQ_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("mpq check failed");

// next-cycle implication, sampled on clk, off during reset
`define MPQ_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("mpq check failed");

`endif

[rtl/core/mpq_pkg.sv]
package mpq_pkg;

    // default sizes
    localparam int QUEUE_DEPTH_DEF   = 64;
    localparam int VISITED_DEPTH_DEF = 64;
    localparam int NODE_BITS_DEF     = 8;

    // modes
    localparam logic [2:0] MODE_INSERT  = 3'd0;
    localparam logic [2:0] MODE_EXTRACT = 3'd1;
    localparam logic [2:0] MODE_ADJUST  = 3'd2;
    localparam logic [2:0] MODE_LOOKUP  = 3'd3;
    localparam logic [2:0] MODE_PATH    = 3'd4;

    // status codes
    localparam logic [2:0] ST_OK       = 3'd0;
    localparam logic [2:0] ST_EMPTY    = 3'd1;
    localparam logic [2:0] ST_FULL     = 3'd2;
    localparam logic [2:0] ST_NOTFOUND = 3'd3;
    localparam logic [2:0] ST_NOPATH   = 3'd4;

    // lookup miss values
    localparam logic [7:0]  MISS_NODE = 8'hFF;
    localparam logic [31:0] MISS_DIST = 32'hFFFF0000;

    typedef struct packed {
        logic [2:0]         mode;
        logic [7:0]         node_id;
        logic [7:0]         pred_id;
        logic signed [31:0] dist_in;
        logic [7:0]         start_id;
    } req_word_t;

    typedef struct packed {
        logic [2:0]         status;
        logic [7:0]         node_out;
        logic [7:0]         pred_out;
        logic signed [31:0] dist_out;
        logic               queue_empty;
        logic               last;
    } rsp_word_t;

endpackage

[rtl/core/mpq_if.sv]
// request channel
interface mpq_req_if;
    logic                valid;
    logic                ready;
    mpq_pkg::req_word_t  data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

// response channel
interface mpq_rsp_if;
    logic                valid;
    logic                ready;
    mpq_pkg::rsp_word_t  data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

[rtl/core/min_priority_queue_with_path_top.sv]
// channel | dir | word        | purpose
// req     | in  | req_word_t  | insert, extract min, adjust, lookup, path query
// rsp     | out | rsp_word_t  | one word per op, one per node for a path
//
// insert: scans from slot 0 for the lowest free slot, ST_FULL when every slot is taken
// extract, adjust, lookup: one full pass over the entry table, one entry table read per cycle
// path: one visited list pass per hop, then one response word per node
// reset clears valid bits, counters and the output valid flag; memories hold garbage
// a new word is taken once the previous op has loaded its last response word;
// a stalled response holds the sequencer only when it needs the output register
module min_priority_queue_with_path_top #(
    parameter int QUEUE_DEPTH   = mpq_pkg::QUEUE_DEPTH_DEF,
    parameter int VISITED_DEPTH = mpq_pkg::VISITED_DEPTH_DEF,
    parameter int NODE_BITS     = mpq_pkg::NODE_BITS_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    mpq_req_if.sink     req,
    mpq_rsp_if.source   rsp
);
    import mpq_pkg::*;

    localparam int QAW = $clog2(QUEUE_DEPTH);
    localparam int QCW = $clog2(QUEUE_DEPTH + 1);
    localparam int VAW = $clog2(VISITED_DEPTH);
    localparam int VCW = $clog2(VISITED_DEPTH + 1);
    localparam int NB  = NODE_BITS;
    localparam int TW  = 2 * NB + 32;

    typedef enum logic [8:0] {
        S_IDLE    = 9'b000000001,
        S_INS     = 9'b000000010,
        S_TSCAN   = 9'b000000100,
        S_TDONE   = 9'b000001000,
        S_VSCAN   = 9'b000010000,
        S_VDONE   = 9'b000100000,
        S_EMIT_RD = 9'b001000000,
        S_EMIT_WR = 9'b010000000,
        S_FIN     = 9'b100000000
    } state_t;

    state_t             state_reg, state_next;
    logic [2:0]         op_reg, op_next;
    logic [NB-1:0]      key_reg, key_next;
    logic [NB-1:0]      pred_in_reg, pred_in_next;
    logic signed [31:0] dist_in_reg, dist_in_next;
    logic [NB-1:0]      u_reg, u_next;
    logic [QCW-1:0]     tidx_reg, tidx_next;
    logic [VCW-1:0]     vidx_reg, vidx_next;
    logic               p_vld_reg, p_vld_next;
    logic [QAW-1:0]     p_idx_reg, p_idx_next;
    logic               hit_reg, hit_next;
    logic               want_last_reg, want_last_next;
    logic [QAW-1:0]     best_idx_reg, best_idx_next;
    logic [NB-1:0]      best_node_reg, best_node_next;
    logic [NB-1:0]      best_pred_reg, best_pred_next;
    logic signed [31:0] best_dist_reg, best_dist_next;
    logic [VCW-1:0]     vcnt_reg, vcnt_next;
    logic [VCW-1:0]     depth_reg, depth_next;
    logic [VAW-1:0]     k_reg, k_next;
    logic [QCW-1:0]     qcount_reg, qcount_next;
    logic [QUEUE_DEPTH-1:0] valid_reg, valid_next;
    logic [2:0]         res_status_reg, res_status_next;
    logic [7:0]         res_node_reg, res_node_next;
    logic [7:0]         res_pred_reg, res_pred_next;
    logic signed [31:0] res_dist_reg, res_dist_next;
    logic               out_valid_reg, out_valid_next;
    rsp_word_t          out_data_reg, out_data_next;

    // entry table memory: node, pred, dist
    logic [TW-1:0]  tmem [QUEUE_DEPTH];
    logic           t_we, t_re;
    logic [QAW-1:0] t_waddr, t_raddr;
    logic [TW-1:0]  t_wdata, t_rdata_reg;

    // visited list memory: node, pred
    logic [2*NB-1:0] vmem [VISITED_DEPTH];
    logic            v_we, v_re;
    logic [VAW-1:0]  v_waddr, v_raddr;
    logic [2*NB-1:0] v_wdata, v_rdata_reg;

    // path stack memory
    logic [NB-1:0]  smem [VISITED_DEPTH];
    logic           s_we, s_re;
    logic [VAW-1:0] s_waddr, s_raddr;
    logic [NB-1:0]  s_wdata, s_rdata_reg;

    logic [NB-1:0]      d_node, d_pred, vd_node, vd_pred;
    logic signed [31:0] d_dist;
    logic               d_valid, out_free, req_fire;

    assign d_node  = t_rdata_reg[TW-1 -: NB];
    assign d_pred  = t_rdata_reg[TW-NB-1 -: NB];
    assign d_dist  = $signed(t_rdata_reg[31:0]);
    assign d_valid = valid_reg[p_idx_reg];
    assign vd_node = v_rdata_reg[2*NB-1 -: NB];
    assign vd_pred = v_rdata_reg[NB-1:0];

    assign out_free  = !out_valid_reg || rsp.ready;
    assign req.ready = (state_reg == S_IDLE);
    assign req_fire  = req.valid && req.ready;
    assign rsp.valid = out_valid_reg;
    assign rsp.data  = out_data_reg;

    // memories
    always_ff @(posedge clk)
    begin
        if (t_we)
        begin
            tmem[t_waddr] <= t_wdata;
        end
        if (t_re)
        begin
            t_rdata_reg <= tmem[t_raddr];
        end
        if (v_we)
        begin
            vmem[v_waddr] <= v_wdata;
        end
        if (v_re)
        begin
            v_rdata_reg <= vmem[v_raddr];
        end
        if (s_we)
        begin
            smem[s_waddr] <= s_wdata;
        end
        if (s_re)
        begin
            s_rdata_reg <= smem[s_raddr];
        end
    end

    // sequencer
    always_comb
    begin
        state_next      = state_reg;
        op_next         = op_reg;
        key_next        = key_reg;
        pred_in_next    = pred_in_reg;
        dist_in_next    = dist_in_reg;
        u_next          = u_reg;
        tidx_next       = tidx_reg;
        vidx_next       = vidx_reg;
        p_vld_next      = p_vld_reg;
        p_idx_next      = p_idx_reg;
        hit_next        = hit_reg;
        want_last_next  = want_last_reg;
        best_idx_next   = best_idx_reg;
        best_node_next  = best_node_reg;
        best_pred_next  = best_pred_reg;
        best_dist_next  = best_dist_reg;
        vcnt_next       = vcnt_reg;
        depth_next      = depth_reg;
        k_next          = k_reg;
        qcount_next     = qcount_reg;
        valid_next      = valid_reg;
        res_status_next = res_status_reg;
        res_node_next   = res_node_reg;
        res_pred_next   = res_pred_reg;
        res_dist_next   = res_dist_reg;
        out_valid_next  = out_valid_reg && !rsp.ready;
        out_data_next   = out_data_reg;

        t_we    = 1'b0;
        t_waddr = p_idx_reg;
        t_wdata = {key_reg, pred_in_reg, dist_in_reg};
        t_re    = 1'b0;
        t_raddr = tidx_reg[QAW-1:0];
        v_we    = 1'b0;
        v_waddr = vcnt_reg[VAW-1:0];
        v_wdata = {best_node_reg, best_pred_reg};
        v_re    = 1'b0;
        v_raddr = vidx_reg[VAW-1:0];
        s_we    = 1'b0;
        s_waddr = depth_reg[VAW-1:0];
        s_wdata = key_reg;
        s_re    = 1'b0;
        s_raddr = k_reg;

        unique case (state_reg)
            S_IDLE:
            begin
                if (req_fire)
                begin
                    op_next         = req.data.mode;
                    key_next        = NB'(req.data.node_id);
                    pred_in_next    = NB'(req.data.pred_id);
                    dist_in_next    = req.data.dist_in;
                    u_next          = NB'(req.data.start_id);
                    tidx_next       = '0;
                    vidx_next       = '0;
                    p_vld_next      = 1'b0;
                    hit_next        = 1'b0;
                    want_last_next  = 1'b0;
                    depth_next      = '0;
                    res_status_next = ST_OK;
                    res_node_next   = '0;
                    res_pred_next   = '0;
                    res_dist_next   = '0;
                    case (req.data.mode)
                        MODE_INSERT:
                        begin
                            state_next = S_INS;
                        end
                        MODE_EXTRACT, MODE_ADJUST, MODE_LOOKUP:
                        begin
                            state_next = S_TSCAN;
                        end
                        MODE_PATH:
                        begin
                            state_next = S_VSCAN;
                        end
                        default:
                        begin
                            state_next = S_FIN;
                        end
                    endcase
                end
            end

            // lowest free slot
            S_INS:
            begin
                if (tidx_reg == QCW'(QUEUE_DEPTH))
                begin
                    res_status_next = ST_FULL;
                    state_next      = S_FIN;
                end
                else if (!valid_reg[tidx_reg[QAW-1:0]])
                begin
                    t_we        = 1'b1;
                    t_waddr     = tidx_reg[QAW-1:0];
                    valid_next[tidx_reg[QAW-1:0]] = 1'b1;
                    qcount_next = qcount_reg + QCW'(1);
                    state_next  = S_FIN;
                end
                else
                begin
                    tidx_next = tidx_reg + QCW'(1);
                end
            end

            // entry table pass, each read issued in the cycle before its compare
            S_TSCAN:
            begin
                if (tidx_reg < QCW'(QUEUE_DEPTH))
                begin
                    t_re       = 1'b1;
                    tidx_next  = tidx_reg + QCW'(1);
                    p_vld_next = 1'b1;
                    p_idx_next = tidx_reg[QAW-1:0];
                end
                else
                begin
                    p_vld_next = 1'b0;
                    if (!p_vld_reg)
                    begin
                        state_next = S_TDONE;
                    end
                end
                if (p_vld_reg && d_valid)
                begin
                    case (op_reg)
                        MODE_EXTRACT:
                        begin
                            if (!hit_reg || (d_dist < best_dist_reg))
                            begin
                                hit_next       = 1'b1;
                                best_idx_next  = p_idx_reg;
                                best_node_next = d_node;
                                best_pred_next = d_pred;
                                best_dist_next = d_dist;
                            end
                        end
                        MODE_ADJUST:
                        begin
                            if (d_node == key_reg)
                            begin
                                hit_next = 1'b1;
                                t_we     = 1'b1;
                            end
                        end
                        default:
                        begin
                            if ((d_node == key_reg) &&
                                (!hit_reg || (d_dist >= best_dist_reg)))
                            begin
                                hit_next       = 1'b1;
                                best_node_next = d_node;
                                best_pred_next = d_pred;
                                best_dist_next = d_dist;
                            end
                        end
                    endcase
                end
            end

            S_TDONE:
            begin
                state_next = S_FIN;
                case (op_reg)
                    MODE_EXTRACT:
                    begin
                        if (!hit_reg)
                        begin
                            res_status_next = ST_EMPTY;
                        end
                        else
                        begin
                            valid_next[best_idx_reg] = 1'b0;
                            qcount_next   = qcount_reg - QCW'(1);
                            res_node_next = 8'(best_node_reg);
                            res_pred_next = 8'(best_pred_reg);
                            res_dist_next = best_dist_reg;
                            if (vcnt_reg < VCW'(VISITED_DEPTH))
                            begin
                                v_we      = 1'b1;
                                vcnt_next = vcnt_reg + VCW'(1);
                            end
                        end
                    end
                    MODE_ADJUST:
                    begin
                        res_status_next = hit_reg ? ST_OK : ST_NOTFOUND;
                    end
                    default:
                    begin
                        if (hit_reg)
                        begin
                            res_node_next = 8'(best_node_reg);
                            res_pred_next = 8'(best_pred_reg);
                            res_dist_next = best_dist_reg;
                        end
                        else
                        begin
                            res_status_next = ST_NOTFOUND;
                            res_node_next   = MISS_NODE;
                            res_pred_next   = MISS_NODE;
                            res_dist_next   = MISS_DIST;
                        end
                    end
                endcase
            end

            // visited list pass: first match for v, last match for a predecessor
            S_VSCAN:
            begin
                if (vidx_reg < vcnt_reg)
                begin
                    v_re       = 1'b1;
                    vidx_next  = vidx_reg + VCW'(1);
                    p_vld_next = 1'b1;
                end
                else
                begin
                    p_vld_next = 1'b0;
                    if (!p_vld_reg)
                    begin
                        state_next = S_VDONE;
                    end
                end
                if (p_vld_reg && (vd_node == key_reg) && (want_last_reg || !hit_reg))
                begin
                    hit_next       = 1'b1;
                    best_node_next = vd_node;
                    best_pred_next = vd_pred;
                end
            end

            // push the hop and decide whether the walk goes on
            S_VDONE:
            begin
                if (!hit_reg)
                begin
                    res_status_next = ST_NOPATH;
                    state_next      = S_FIN;
                end
                else
                begin
                    s_we       = 1'b1;
                    depth_next = depth_reg + VCW'(1);
                    if (best_node_reg == u_reg)
                    begin
                        k_next     = depth_reg[VAW-1:0];
                        state_next = S_EMIT_RD;
                    end
                    else if (depth_reg + VCW'(1) >= VCW'(VISITED_DEPTH))
                    begin
                        res_status_next = ST_NOPATH;
                        state_next      = S_FIN;
                    end
                    else
                    begin
                        key_next       = best_pred_reg;
                        want_last_next = 1'b1;
                        hit_next       = 1'b0;
                        vidx_next      = '0;
                        state_next     = S_VSCAN;
                    end
                end
            end

            S_EMIT_RD:
            begin
                s_re       = 1'b1;
                state_next = S_EMIT_WR;
            end

            // path words from u to v
            S_EMIT_WR:
            begin
                if (out_free)
                begin
                    out_valid_next             = 1'b1;
                    out_data_next.status       = ST_OK;
                    out_data_next.node_out     = 8'(s_rdata_reg);
                    out_data_next.pred_out     = '0;
                    out_data_next.dist_out     = '0;
                    out_data_next.queue_empty  = (qcount_reg == '0);
                    out_data_next.last         = (k_reg == '0);
                    if (k_reg == '0)
                    begin
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        k_next     = k_reg - VAW'(1);
                        state_next = S_EMIT_RD;
                    end
                end
            end

            S_FIN:
            begin
                if (out_free)
                begin
                    out_valid_next             = 1'b1;
                    out_data_next.status       = res_status_reg;
                    out_data_next.node_out     = res_node_reg;
                    out_data_next.pred_out     = res_pred_reg;
                    out_data_next.dist_out     = res_dist_reg;
                    out_data_next.queue_empty  = (qcount_reg == '0);
                    out_data_next.last         = 1'b1;
                    state_next                 = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            p_vld_reg     <= 1'b0;
            vcnt_reg      <= '0;
            qcount_reg    <= '0;
            valid_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            p_vld_reg     <= p_vld_next;
            vcnt_reg      <= vcnt_next;
            qcount_reg    <= qcount_next;
            valid_reg     <= valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // working registers
    always_ff @(posedge clk)
    begin
        op_reg         <= op_next;
        key_reg        <= key_next;
        pred_in_reg    <= pred_in_next;
        dist_in_reg    <= dist_in_next;
        u_reg          <= u_next;
        tidx_reg       <= tidx_next;
        vidx_reg       <= vidx_next;
        p_idx_reg      <= p_idx_next;
        hit_reg        <= hit_next;
        want_last_reg  <= want_last_next;
        best_idx_reg   <= best_idx_next;
        best_node_reg  <= best_node_next;
        best_pred_reg  <= best_pred_next;
        best_dist_reg  <= best_dist_next;
        depth_reg      <= depth_next;
        k_reg          <= k_next;
        res_status_reg <= res_status_next;
        res_node_reg   <= res_node_next;
        res_pred_reg   <= res_pred_next;
        res_dist_reg   <= res_dist_next;
        out_data_reg   <= out_data_next;
    end

endmodule

[rtl/core/mpq_checker.sv]
`include "min_priority_queue_with_path_top_defines.svh"

module mpq_checker (
    input logic                clk,
    input logic                rst_n,
    input logic                req_valid,
    input logic                req_ready,
    input logic                rsp_valid,
    input logic                rsp_ready,
    input mpq_pkg::rsp_word_t  rsp_data
);
    import mpq_pkg::*;

    // a stalled response word holds
    `MPQ_ASSERT_NEXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_data))

    // one op at a time: no new word right after one is taken
    `MPQ_ASSERT_NEXT(a_one_op, req_valid && req_ready, !req_ready)

    // only a path emits words that are not last, and those are ok
    `MPQ_ASSERT_NOW(a_multi_ok, rsp_valid && !rsp_data.last, rsp_data.status == ST_OK)

    // a lookup miss (one with a nonzero distance) reports the all-ones node
    `MPQ_ASSERT_NOW(a_miss_node, rsp_valid && (rsp_data.status == ST_NOTFOUND) &&
        (rsp_data.dist_out != '0), rsp_data.node_out == MISS_NODE)

endmodule

bind min_priority_queue_with_path_top mpq_checker u_mpq_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .req_valid (req.valid),
    .req_ready (req.ready),
    .rsp_valid (rsp.valid),
    .rsp_ready (rsp.ready),
    .rsp_data  (rsp.data)
);

[bench/tb_min_priority_queue_with_path_top.sv]
`timescale 1ns / 100ps

module tb_min_priority_queue_with_path_top;
    import mpq_pkg::*;

    localparam int SLOTS      = QUEUE_DEPTH_DEF;
    localparam int HOPS       = VISITED_DEPTH_DEF;
    localparam int STALL_MAX  = 20000;
    localparam int TAIL_WAIT  = 300;
    localparam logic [2:0] MODE_SPARE_LO = 3'd5;
    localparam logic [2:0] MODE_SPARE_HI = 3'd7;

    logic clk;
    logic rst_n;

    mpq_req_if req ();
    mpq_rsp_if rsp ();

    min_priority_queue_with_path_top u_top (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req),
        .rsp   (rsp)
    );

    // shadow of the queue and the visited list
    logic               slot_valid [SLOTS];
    logic [7:0]         slot_node  [SLOTS];
    logic [7:0]         slot_pred  [SLOTS];
    logic signed [31:0] slot_dist  [SLOTS];
    logic [7:0]         seen_node  [HOPS];
    logic [7:0]         seen_pred  [HOPS];
    int                 seen_count;

    rsp_word_t pending_words[$];
    int        error_count;
    int        words_sent;
    int        words_checked;
    int        path_words;
    int        quiet_cycles;
    int        stall_count;
    int        ready_hold;
    bit        quiet;

    // clock
    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    function automatic bit queue_drained();
        foreach (slot_valid[i])
        begin
            if (slot_valid[i])
                return 1'b0;
        end
        return 1'b1;
    endfunction

    function automatic void expect_word(logic [2:0] st, logic [7:0] nd, logic [7:0] pd,
                                        logic signed [31:0] ds, logic lst);
        rsp_word_t w;
        w.status      = st;
        w.node_out    = nd;
        w.pred_out    = pd;
        w.dist_out    = ds;
        w.queue_empty = queue_drained();
        w.last        = lst;
        pending_words = {pending_words, w};
    endfunction

    // walk predecessors from v back to u through the visited list
    function automatic void predict_path(logic [7:0] u, logic [7:0] v);
        int         at;
        logic [7:0] trail[$];
        logic [7:0] cur_node;
        logic [7:0] cur_pred;
        at = -1;
        for (int i = 0; i < seen_count; i++)
        begin
            if (at < 0 && seen_node[i] == v)
                at = i;
        end
        if (at < 0)
        begin
            expect_word(ST_NOPATH, 8'd0, 8'd0, 32'sd0, 1'b1);
            return;
        end
        trail = {trail, v};
        cur_node = seen_node[at];
        cur_pred = seen_pred[at];
        while (cur_node != u)
        begin
            at = -1;
            for (int i = 0; i < seen_count; i++)
            begin
                if (seen_node[i] == cur_pred)
                    at = i;
            end
            if (trail.size() >= HOPS || at < 0)
            begin
                expect_word(ST_NOPATH, 8'd0, 8'd0, 32'sd0, 1'b1);
                return;
            end
            trail = {trail, cur_pred};
            cur_node = seen_node[at];
            cur_pred = seen_pred[at];
        end
        for (int k = trail.size() - 1; k >= 0; k--)
        begin
            expect_word(ST_OK, trail[k], 8'd0, 32'sd0, k == 0);
            path_words++;
        end
    endfunction

    // expected response words for one accepted request word
    function automatic void predict_op(req_word_t w);
        int  best;
        bit  hit;
        best = 0;
        hit  = 1'b0;
        case (w.mode)
            MODE_INSERT:
            begin
                for (int i = 0; i < SLOTS && !hit; i++)
                begin
                    if (!slot_valid[i])
                    begin
                        slot_valid[i] = 1'b1;
                        slot_node[i]  = w.node_id;
                        slot_pred[i]  = w.pred_id;
                        slot_dist[i]  = w.dist_in;
                        hit = 1'b1;
                    end
                end
                expect_word(hit ? ST_OK : ST_FULL, 8'd0, 8'd0, 32'sd0, 1'b1);
            end
            MODE_EXTRACT:
            begin
                for (int i = 0; i < SLOTS; i++)
                begin
                    if (slot_valid[i] && (!hit || slot_dist[i] < slot_dist[best]))
                    begin
                        best = i;
                        hit  = 1'b1;
                    end
                end
                if (!hit)
                    expect_word(ST_EMPTY, 8'd0, 8'd0, 32'sd0, 1'b1);
                else
                begin
                    slot_valid[best] = 1'b0;
                    if (seen_count < HOPS)
                    begin
                        seen_node[seen_count] = slot_node[best];
                        seen_pred[seen_count] = slot_pred[best];
                        seen_count++;
                    end
                    expect_word(ST_OK, slot_node[best], slot_pred[best], slot_dist[best], 1'b1);
                end
            end
            MODE_ADJUST:
            begin
                for (int i = 0; i < SLOTS; i++)
                begin
                    if (slot_valid[i] && slot_node[i] == w.node_id)
                    begin
                        slot_dist[i] = w.dist_in;
                        slot_pred[i] = w.pred_id;
                        hit = 1'b1;
                    end
                end
                expect_word(hit ? ST_OK : ST_NOTFOUND, 8'd0, 8'd0, 32'sd0, 1'b1);
            end
            MODE_LOOKUP:
            begin
                for (int i = 0; i < SLOTS; i++)
                begin
                    if (slot_valid[i] && slot_node[i] == w.node_id &&
                        (!hit || slot_dist[i] >= slot_dist[best]))
                    begin
                        best = i;
                        hit  = 1'b1;
                    end
                end
                if (!hit)
                    expect_word(ST_NOTFOUND, MISS_NODE, MISS_NODE, MISS_DIST, 1'b1);
                else
                    expect_word(ST_OK, slot_node[best], slot_pred[best], slot_dist[best], 1'b1);
            end
            MODE_PATH:
                predict_path(w.start_id, w.node_id);
            default:
                expect_word(ST_OK, 8'd0, 8'd0, 32'sd0, 1'b1);
        endcase
    endfunction

    // send one request word, with an optional idle burst in front
    task automatic send_word(logic [2:0] md, logic [7:0] nd, logic [7:0] pd,
                             logic signed [31:0] ds, logic [7:0] st);
        req_word_t w;
        int        gap;
        w.mode     = md;
        w.node_id  = nd;
        w.pred_id  = pd;
        w.dist_in  = ds;
        w.start_id = st;
        gap = (!quiet && $urandom_range(0, 3) == 0) ? $urandom_range(1, 16) : 0;
        if (gap > 0)
        begin
            req.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        req.valid <= 1'b1;
        req.data  <= w;
        do
            @(posedge clk);
        while (!req.ready);
        predict_op(w);
        words_sent++;
    endtask

    task automatic wait_drain();
        req.valid <= 1'b0;
        while (pending_words.size() != 0)
            @(posedge clk);
    endtask

    function automatic logic signed [31:0] rand_dist();
        return $signed($urandom());
    endfunction

    // directed: empty queue, misses, extremes, spare modes, ties
    task automatic test_corners();
        send_word(MODE_EXTRACT, 8'd0, 8'd0, 32'sd0, 8'd0);
        send_word(MODE_LOOKUP, 8'hFF, 8'd0, 32'sd0, 8'd0);
        send_word(MODE_ADJUST, 8'h00, 8'hFF, 32'sd5, 8'd0);
        send_word(MODE_PATH, 8'h12, 8'd0, 32'sd0, 8'h12);
        for (int m = int'(MODE_SPARE_LO); m <= int'(MODE_SPARE_HI); m++)
            send_word(3'(m), 8'hFF, 8'hFF, 32'sh7FFFFFFF, 8'hFF);
        send_word(MODE_INSERT, 8'hFF, 8'hFF, 32'sh7FFFFFFF, 8'hFF);
        send_word(MODE_INSERT, 8'h00, 8'h00, 32'sh80000000, 8'h00);
        send_word(MODE_INSERT, 8'hAA, 8'h55, 32'sh00010000, 8'h00);
        send_word(MODE_INSERT, 8'h55, 8'hAA, 32'sh00010000, 8'h00);
        send_word(MODE_INSERT, 8'hAA, 8'h00, 32'sh00010000, 8'h00);
        send_word(MODE_LOOKUP, 8'hAA, 8'd0, 32'sd0, 8'd0);
        send_word(MODE_ADJUST, 8'hAA, 8'h00, -32'sd65536, 8'd0);
        send_word(MODE_LOOKUP, 8'hAA, 8'd0, 32'sd0, 8'd0);
        repeat (6) send_word(MODE_EXTRACT, 8'd0, 8'd0, 32'sd0, 8'd0);
        send_word(MODE_PATH, 8'hAA, 8'd0, 32'sd0, 8'hAA);
        send_word(MODE_PATH, 8'h55, 8'd0, 32'sd0, 8'hAA);
        send_word(MODE_PATH, 8'h55, 8'd0, 32'sd0, 8'h00);
    endtask

    // fill every slot, some with tied distances, overflow once, then extract half of them
    task automatic test_full_queue();
        for (int i = 0; i <= SLOTS; i++)
            send_word(MODE_INSERT, i[7:0], 8'h00, (i % 3 == 0) ? 32'sd0 : rand_dist(), 8'd0);
        wait_drain();
        repeat (SLOTS / 2) send_word(MODE_EXTRACT, 8'd0, 8'd0, 32'sd0, 8'd0);
    endtask

    // search rounds: insert a small graph, relax, extract, query paths
    task automatic test_search_rounds(int budget);
        int         n;
        logic [7:0] nd;
        for (int used = 0; used < budget; )
        begin
            n = $urandom_range(2, 8);
            for (int i = 0; i < n; i++)
            begin
                nd = 8'($urandom_range(0, 15));
                send_word(MODE_INSERT, nd, 8'($urandom_range(0, 15)),
                          $signed($urandom_range(0, 7) << 16), 8'($urandom()));
            end
            used += n;
            repeat ($urandom_range(0, 3))
            begin
                send_word(MODE_ADJUST, 8'($urandom_range(0, 15)), 8'($urandom_range(0, 15)),
                          $signed($urandom_range(0, 7) << 15), 8'($urandom()));
                send_word(MODE_LOOKUP, 8'($urandom_range(0, 15)), 8'($urandom()),
                          rand_dist(), 8'($urandom()));
                used += 2;
            end
            repeat (n + $urandom_range(0, 1))
            begin
                send_word(MODE_EXTRACT, 8'($urandom()), 8'($urandom()), rand_dist(),
                          8'($urandom()));
                used++;
            end
            repeat ($urandom_range(1, 3))
            begin
                send_word(MODE_PATH, 8'($urandom_range(0, 15)), 8'($urandom()), rand_dist(),
                          8'($urandom_range(0, 15)));
                used++;
            end
            // noise: anything the fields allow
            if ($urandom_range(0, 2) == 0)
            begin
                send_word(3'($urandom()), 8'($urandom()), 8'($urandom()), rand_dist(),
                          8'($urandom()));
                used++;
            end
        end
    endtask

    // response ready with random stall bursts, held high when quiet
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp.ready  <= 1'b0;
            ready_hold <= 0;
        end
        else if (quiet)
            rsp.ready <= 1'b1;
        else if (ready_hold > 0)
        begin
            rsp.ready  <= 1'b0;
            ready_hold <= ready_hold - 1;
        end
        else if ($urandom_range(0, 5) == 0)
        begin
            rsp.ready  <= 1'b0;
            ready_hold <= $urandom_range(0, 15);
        end
        else
            rsp.ready <= 1'b1;
    end

    // check each response word against the oldest expectation
    always @(posedge clk)
    begin
        rsp_word_t want;
        if (rst_n && rsp.valid && rsp.ready)
        begin
            words_checked++;
            if (pending_words.size() == 0)
            begin
                $display("%t unexpected word: actual %p", $time, rsp.data);
                error_count++;
            end
            else
            begin
                want = pending_words.pop_front();
                if (rsp.data.status !== want.status)
                begin
                    $display("%t status: expected %0d actual %0d", $time, want.status,
                             rsp.data.status);
                    error_count++;
                end
                if (rsp.data.node_out !== want.node_out)
                begin
                    $display("%t node_out: expected %0d actual %0d", $time, want.node_out,
                             rsp.data.node_out);
                    error_count++;
                end
                if (rsp.data.pred_out !== want.pred_out)
                begin
                    $display("%t pred_out: expected %0d actual %0d", $time, want.pred_out,
                             rsp.data.pred_out);
                    error_count++;
                end
                if (rsp.data.dist_out !== want.dist_out)
                begin
                    $display("%t dist_out: expected %h actual %h", $time, want.dist_out,
                             rsp.data.dist_out);
                    error_count++;
                end
                if (rsp.data.queue_empty !== want.queue_empty)
                begin
                    $display("%t queue_empty: expected %b actual %b", $time,
                             want.queue_empty, rsp.data.queue_empty);
                    error_count++;
                end
                if (rsp.data.last !== want.last)
                begin
                    $display("%t last: expected %b actual %b", $time, want.last,
                             rsp.data.last);
                    error_count++;
                end
            end
        end
    end

    // watchdog on cycles with no accepted word on either side
    always @(posedge clk)
    begin
        if ((req.valid && req.ready) || (rsp.valid && rsp.ready))
            stall_count <= 0;
        else
            stall_count <= stall_count + 1;
        if (stall_count >= STALL_MAX)
        begin
            $display("timeout at %t, %0d words outstanding", $time, pending_words.size());
            $display("status: fail");
            $finish;
        end
    end

    initial
    begin
        foreach (slot_valid[i])
        begin
            slot_valid[i] = 1'b0;
            slot_node[i]  = '0;
            slot_pred[i]  = '0;
            slot_dist[i]  = '0;
        end
        seen_count    = 0;
        error_count   = 0;
        words_sent    = 0;
        words_checked = 0;
        path_words    = 0;
        stall_count   = 0;
        quiet         = 1'b0;
        rst_n         = 1'b0;
        req.valid     = 1'b0;
        req.data      = '0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_corners();
        test_full_queue();
        test_search_rounds(60);
        wait_drain();
        quiet = 1'b1;
        test_search_rounds(25);
        req.valid <= 1'b0;

        // let the last words come out, then a little more
        while (pending_words.size() != 0)
            @(posedge clk);
        quiet_cycles = 0;
        while (quiet_cycles < TAIL_WAIT)
        begin
            @(posedge clk);
            quiet_cycles++;
        end
        if (pending_words.size() != 0)
        begin
            $display("%0d expected words never arrived", pending_words.size());
            error_count++;
        end

        $display("covered %0d requests and %0d responses, %0d of them path nodes,",
                 words_sent, words_checked, path_words);
        $display("with a full queue, an empty queue, misses and %0d visited nodes",
                 seen_count);
        if (error_count == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
